@@ rtl/fcm_pkg.sv @@
// Shared constants, types and helpers for the fuzzy cognitive map update block.
// No dependencies; every other file imports this package.
package fcm_pkg;

    localparam int MAX_CONCEPTS = 16;
    localparam int MAX_EDGES    = 64;

    localparam int IDXW = 4;     // concept_index / target_index field width
    localparam int VALW = 16;    // Q8.8 value width
    localparam int NAW  = $clog2(MAX_CONCEPTS);
    localparam int IXW  = (NAW > IDXW) ? NAW : IDXW;
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int NUMW = VALW + 8;          // value scaled by 256
    localparam int PRDW = 2 * VALW;
    localparam int DIV_STEPS = NUMW;
    localparam int DCW  = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_SET    = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_WEIGHT = 3'd4;
    localparam logic [2:0] ACT_RUN    = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {NSEL_CI, NSEL_I, NSEL_TGT} node_sel_t;
    typedef enum logic {ESEL_J, ESEL_K} edge_sel_t;
    typedef enum logic [2:0] {
        RES_HOLD, RES_OK, RES_ABSENT, RES_FULL, RES_VALUE, RES_WEIGHT
    } res_t;

    typedef struct packed {
        logic      latch;
        logic      load_node;
        logic      set_node;
        logic      wr_target;
        logic      add_edge;
        node_sel_t node_sel;
        edge_sel_t edge_sel;
        logic      i_clr;
        logic      i_inc;
        logic      j_clr;
        logic      j_inc;
        logic      k_clr;
        logic      k_inc;
        logic      cap_tgt;
        logic      cap_weight;
        logic      cap_src;
        logic      cap_val_t;
        logic      div_start;
        logic      mul;
        res_t      res;
        logic      out_load;
    } fcm_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       ci_in_range;
        logic       ci_ok;
        logic       list_full;
        logic       i_end;
        logic       present_i;
        logic       j_end;
        logic       k_end;
        logic       run_hit;
        logic       find_hit;
        logic       weight_hit;
        logic       div_done;
    } fcm_sts_t;

    function automatic logic [IXW-1:0] idx_wide(input logic [IDXW-1:0] x);
        return IXW'(x);
    endfunction

    function automatic logic idx_in_range(input logic [IDXW-1:0] x);
        return ({1'b0, IXW'(x)} < (IXW+1)'(MAX_CONCEPTS));
    endfunction

endpackage

@@ rtl/fcm_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on fcm_pkg for field widths.
interface fcm_in_if;
    import fcm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [2:0]             action;
    logic [IDXW-1:0]        concept_index;
    logic [IDXW-1:0]        target_index;
    logic signed [VALW-1:0] data_value;
    logic signed [VALW-1:0] limit_value;

    modport source (output valid, action, concept_index, target_index, data_value,
                    limit_value, input ready);
    modport sink (input valid, action, concept_index, target_index, data_value,
                  limit_value, output ready);
endinterface

interface fcm_out_if;
    import fcm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [VALW-1:0] read_data;
    logic [1:0]             status;

    modport source (output valid, read_data, status, input ready);
    modport sink (input valid, read_data, status, output ready);
endinterface

@@ rtl/fcm_div.sv @@
// Iterative signed divider: (value * 256) / threshold, truncated, saturated to 16 bits.
// One quotient bit per cycle. Depends on fcm_pkg.
module fcm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [fcm_pkg::VALW-1:0] value,
    input  logic signed [fcm_pkg::VALW-1:0] limit,
    output logic                            done,
    output logic signed [fcm_pkg::VALW-1:0] quot
);
    import fcm_pkg::*;

    logic                   busy_reg, fin_reg, done_reg;
    logic [DCW-1:0]         cnt_reg;
    logic [VALW-1:0]        rem_reg;
    logic [NUMW-1:0]        qm_reg;
    logic [VALW-1:0]        den_reg;
    logic                   neg_reg, zden_reg, vneg_reg, vzero_reg;
    logic signed [VALW-1:0] quot_reg;

    logic [NUMW-1:0] num_mag;
    logic [VALW-1:0] den_mag;
    logic [VALW:0]   shifted;
    logic [VALW:0]   trial;
    logic            take;
    logic signed [VALW-1:0] sat_q;

    always_comb
    begin
        num_mag = value[VALW-1] ? NUMW'(-{value, 8'h00}) : {value, 8'h00};
        den_mag = limit[VALW-1] ? VALW'(-limit) : limit;
        shifted = {rem_reg, qm_reg[NUMW-1]};
        trial   = shifted - {1'b0, den_reg};
        take    = (shifted >= {1'b0, den_reg});
        if (zden_reg)
        begin
            if (vzero_reg)
                sat_q = '0;
            else if (vneg_reg)
                sat_q = {1'b1, {(VALW-1){1'b0}}};
            else
                sat_q = {1'b0, {(VALW-1){1'b1}}};
        end
        else if (neg_reg)
        begin
            if (qm_reg > NUMW'(32768))
                sat_q = {1'b1, {(VALW-1){1'b0}}};
            else
                sat_q = VALW'(-qm_reg);
        end
        else if (qm_reg > NUMW'(32767))
            sat_q = {1'b0, {(VALW-1){1'b1}}};
        else
            sat_q = VALW'(qm_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= (limit != '0);
                fin_reg  <= (limit == '0);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            qm_reg    <= num_mag;
            den_reg   <= den_mag;
            neg_reg   <= value[VALW-1] ^ limit[VALW-1];
            zden_reg  <= (limit == '0);
            vneg_reg  <= value[VALW-1];
            vzero_reg <= (value == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[VALW-1:0] : shifted[VALW-1:0];
            qm_reg  <= {qm_reg[NUMW-2:0], take};
        end
        if (fin_reg)
            quot_reg <= sat_q;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/fcm_dp.sv @@
// Datapath: concept and relationship stores, scan counters, divider, multiply and update.
// Driven by fcm_cmd_t, reports fcm_sts_t. Depends on fcm_pkg and fcm_div.
module fcm_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fcm_pkg::fcm_cmd_t               cmd,
    output fcm_pkg::fcm_sts_t               sts,
    input  logic [2:0]                      action,
    input  logic [fcm_pkg::IDXW-1:0]        concept_index,
    input  logic [fcm_pkg::IDXW-1:0]        target_index,
    input  logic signed [fcm_pkg::VALW-1:0] data_value,
    input  logic signed [fcm_pkg::VALW-1:0] limit_value,
    output logic signed [fcm_pkg::VALW-1:0] read_data,
    output logic [1:0]                      status
);
    import fcm_pkg::*;

    // concept store
    logic signed [VALW-1:0] val_mem [MAX_CONCEPTS];
    logic signed [VALW-1:0] thr_mem [MAX_CONCEPTS];
    logic [MAX_CONCEPTS-1:0] present_reg;
    logic signed [VALW-1:0] val_rd_reg, thr_rd_reg;

    // relationship store
    logic [IDXW-1:0]        esrc_mem [MAX_EDGES];
    logic [IDXW-1:0]        etgt_mem [MAX_EDGES];
    logic signed [VALW-1:0] ew_mem   [MAX_EDGES];
    logic [IDXW-1:0]        erd_src_reg, erd_tgt_reg;
    logic signed [VALW-1:0] erd_w_reg;
    logic [ECW-1:0]         count_reg;

    // item and working registers
    logic [2:0]             act_reg;
    logic [IDXW-1:0]        ci_reg, ti_reg, tgt_reg;
    logic signed [VALW-1:0] dv_reg, lv_reg;
    logic [NAW:0]           i_reg;
    logic [ECW-1:0]         j_reg, k_reg;
    logic signed [VALW-1:0] w_reg, val_i_reg, thr_i_reg, val_t_reg;
    logic signed [PRDW-1:0] prod_reg;
    logic signed [VALW-1:0] res_data_reg, out_data_reg;
    logic [1:0]             res_status_reg, out_status_reg;

    logic                   div_done;
    logic signed [VALW-1:0] div_q;

    logic [IXW-1:0]         ci_w, etgt_w, tgt_w;
    logic [NAW-1:0]         ci_addr, etgt_addr, tgt_addr, rd_addr;
    logic [EAW-1:0]         erd_addr;
    logic                   src_is_i, tgt_ok;
    logic signed [NUMW-1:0] prod_sh;
    logic signed [NUMW:0]   sum_w;
    logic signed [VALW-1:0] sum_sat, upd_val;

    fcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .value (val_i_reg),
        .limit (thr_i_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        ci_w      = idx_wide(ci_reg);
        ci_addr   = ci_w[NAW-1:0];
        etgt_w    = idx_wide(erd_tgt_reg);
        etgt_addr = etgt_w[NAW-1:0];
        tgt_w     = idx_wide(tgt_reg);
        tgt_addr  = tgt_w[NAW-1:0];
        case (cmd.node_sel)
            NSEL_CI:  rd_addr = ci_addr;
            NSEL_I:   rd_addr = i_reg[NAW-1:0];
            NSEL_TGT: rd_addr = tgt_addr;
            default:  rd_addr = ci_addr;
        endcase
        erd_addr = (cmd.edge_sel == ESEL_K) ? k_reg[EAW-1:0] : j_reg[EAW-1:0];

        src_is_i = ({1'b0, idx_wide(erd_src_reg)} == (IXW+1)'(i_reg));
        tgt_ok   = idx_in_range(erd_tgt_reg) && present_reg[etgt_addr];

        // floor shift of the product, then saturating add and clamp at the threshold
        prod_sh = prod_reg[PRDW-1:8];
        sum_w   = {{(NUMW+1-VALW){val_t_reg[VALW-1]}}, val_t_reg} + {prod_sh[NUMW-1], prod_sh};
        if (sum_w > (NUMW+1)'(32767))
            sum_sat = {1'b0, {(VALW-1){1'b1}}};
        else if (sum_w < -(NUMW+1)'(32768))
            sum_sat = {1'b1, {(VALW-1){1'b0}}};
        else
            sum_sat = sum_w[VALW-1:0];
        upd_val = (sum_sat > thr_i_reg) ? thr_i_reg : sum_sat;

        sts.action      = act_reg;
        sts.ci_in_range = idx_in_range(ci_reg);
        sts.ci_ok       = idx_in_range(ci_reg) && present_reg[ci_addr];
        sts.list_full   = (count_reg == ECW'(MAX_EDGES));
        sts.i_end       = (i_reg == (NAW+1)'(MAX_CONCEPTS));
        sts.present_i   = present_reg[i_reg[NAW-1:0]];
        sts.j_end       = (j_reg == count_reg);
        sts.k_end       = (k_reg == count_reg);
        sts.run_hit     = src_is_i && tgt_ok;
        sts.find_hit    = src_is_i && (erd_tgt_reg == tgt_reg);
        sts.weight_hit  = (erd_src_reg == ci_reg) && (erd_tgt_reg == ti_reg);
        sts.div_done    = div_done;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            count_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cmd.load_node)
                present_reg[ci_addr] <= 1'b1;
            if (cmd.add_edge)
                count_reg <= count_reg + 1'b1;
            if (cmd.i_clr)
                i_reg <= '0;
            else if (cmd.i_inc)
                i_reg <= i_reg + 1'b1;
            if (cmd.j_clr)
                j_reg <= '0;
            else if (cmd.j_inc)
                j_reg <= j_reg + 1'b1;
            if (cmd.k_clr)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + 1'b1;
        end
    end

    // stores and payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_node || cmd.set_node)
            val_mem[ci_addr] <= dv_reg;
        else if (cmd.wr_target)
            val_mem[tgt_addr] <= upd_val;
        if (cmd.load_node)
            thr_mem[ci_addr] <= lv_reg;
        val_rd_reg <= val_mem[rd_addr];
        thr_rd_reg <= thr_mem[rd_addr];

        if (cmd.add_edge)
        begin
            esrc_mem[count_reg[EAW-1:0]] <= ci_reg;
            etgt_mem[count_reg[EAW-1:0]] <= ti_reg;
            ew_mem[count_reg[EAW-1:0]]   <= dv_reg;
        end
        erd_src_reg <= esrc_mem[erd_addr];
        erd_tgt_reg <= etgt_mem[erd_addr];
        erd_w_reg   <= ew_mem[erd_addr];

        if (cmd.latch)
        begin
            act_reg <= action;
            ci_reg  <= concept_index;
            ti_reg  <= target_index;
            dv_reg  <= data_value;
            lv_reg  <= limit_value;
        end
        if (cmd.cap_tgt)
            tgt_reg <= erd_tgt_reg;
        if (cmd.cap_weight)
            w_reg <= erd_w_reg;
        if (cmd.cap_src)
        begin
            val_i_reg <= val_rd_reg;
            thr_i_reg <= thr_rd_reg;
        end
        if (cmd.cap_val_t)
            val_t_reg <= val_rd_reg;
        if (cmd.mul)
            prod_reg <= div_q * w_reg;

        case (cmd.res)
            RES_OK:
            begin
                res_data_reg   <= '0;
                res_status_reg <= ST_OK;
            end
            RES_ABSENT:
            begin
                res_data_reg   <= '0;
                res_status_reg <= ST_ABSENT;
            end
            RES_FULL:
            begin
                res_data_reg   <= '0;
                res_status_reg <= ST_FULL;
            end
            RES_VALUE:
            begin
                res_data_reg   <= val_rd_reg;
                res_status_reg <= ST_OK;
            end
            RES_WEIGHT:
            begin
                res_data_reg   <= erd_w_reg;
                res_status_reg <= ST_OK;
            end
            default:
            begin
                res_data_reg   <= res_data_reg;
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_data_reg   <= res_data_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign read_data = out_data_reg;
    assign status    = out_status_reg;

endmodule

@@ rtl/fcm_ctrl.sv @@
// Controller: sequences actions, scans and the update pass; owns the handshakes.
// Drives fcm_cmd_t, reads fcm_sts_t. Depends on fcm_pkg.
module fcm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  fcm_pkg::fcm_sts_t sts,
    output fcm_pkg::fcm_cmd_t cmd
);
    import fcm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_READ_WAIT, S_W_RD, S_W_CHK, S_RUN_I, S_RUN_JRD,
        S_RUN_JCHK, S_F_RD, S_F_CHK, S_S_CAP, S_T_CAP, S_DIV_WAIT, S_UPD, S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESP;
                case (sts.action)
                    ACT_LOAD:
                    begin
                        cmd.load_node = sts.ci_in_range;
                        cmd.res = sts.ci_in_range ? RES_OK : RES_ABSENT;
                    end
                    ACT_ADD:
                    begin
                        cmd.add_edge = !sts.list_full;
                        cmd.res = sts.list_full ? RES_FULL : RES_OK;
                    end
                    ACT_SET:
                    begin
                        cmd.set_node = sts.ci_ok;
                        cmd.res = sts.ci_ok ? RES_OK : RES_ABSENT;
                    end
                    ACT_READ:
                    begin
                        cmd.node_sel = NSEL_CI;
                        if (sts.ci_ok)
                            state_next = S_READ_WAIT;
                        else
                            cmd.res = RES_ABSENT;
                    end
                    ACT_WEIGHT:
                    begin
                        cmd.k_clr  = 1'b1;
                        state_next = S_W_RD;
                    end
                    ACT_RUN:
                    begin
                        cmd.i_clr  = 1'b1;
                        state_next = S_RUN_I;
                    end
                    default: cmd.res = RES_OK;
                endcase
            end
            S_READ_WAIT:
            begin
                cmd.res    = RES_VALUE;
                state_next = S_RESP;
            end
            S_W_RD:
            begin
                cmd.edge_sel = ESEL_K;
                if (sts.k_end)
                begin
                    cmd.res    = RES_ABSENT;
                    state_next = S_RESP;
                end
                else
                    state_next = S_W_CHK;
            end
            S_W_CHK:
            begin
                if (sts.weight_hit)
                begin
                    cmd.res    = RES_WEIGHT;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_W_RD;
                end
            end
            S_RUN_I:
            begin
                if (sts.i_end)
                begin
                    cmd.res    = RES_OK;
                    state_next = S_RESP;
                end
                else if (!sts.present_i)
                    cmd.i_inc = 1'b1;
                else
                begin
                    cmd.j_clr  = 1'b1;
                    state_next = S_RUN_JRD;
                end
            end
            S_RUN_JRD:
            begin
                cmd.edge_sel = ESEL_J;
                if (sts.j_end)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_RUN_I;
                end
                else
                    state_next = S_RUN_JCHK;
            end
            S_RUN_JCHK:
            begin
                if (sts.run_hit)
                begin
                    cmd.cap_tgt = 1'b1;
                    cmd.k_clr   = 1'b1;
                    state_next  = S_F_RD;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_RUN_JRD;
                end
            end
            S_F_RD:
            begin
                cmd.edge_sel = ESEL_K;
                state_next   = S_F_CHK;
            end
            S_F_CHK:
            begin
                // the current edge itself matches, so this search always ends
                if (sts.find_hit)
                begin
                    cmd.cap_weight = 1'b1;
                    cmd.node_sel   = NSEL_I;
                    state_next     = S_S_CAP;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_S_CAP:
            begin
                cmd.cap_src  = 1'b1;
                cmd.node_sel = NSEL_TGT;
                state_next   = S_T_CAP;
            end
            S_T_CAP:
            begin
                cmd.cap_val_t = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.wr_target = 1'b1;
                cmd.j_inc     = 1'b1;
                state_next    = S_RUN_JRD;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register reloaded while a result is waiting");
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");
    a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> ($past(state_reg) == S_DIV_WAIT))
        else $error("update without a fresh product");
`endif

endmodule

@@ rtl/fuzzy_cognitive_map_update.sv @@
// Top level of the fuzzy cognitive map update block.
// Joins fcm_ctrl and fcm_dp; depends on fcm_pkg and the interfaces in fcm_if.
//
//  channel     direction  payload
//  in_item     sink       action, concept_index, target_index, data_value, limit_value
//  out_result  source     read_data, status
//
// Every item passes through accept, dispatch and respond; load, add, set and undefined
// actions take only those, read value adds a read wait state. Read weight examines the
// list one entry at a time, as there is a single relationship read port. A run visits
// every concept slot in turn and scans the list for each present concept. Each applied
// relationship searches the list for the first matching pair, then waits on the divider,
// one quotient bit a cycle; with a zero threshold the divider skips its iterations.
// Of the stores, reset clears only the present bits and the list count; no clearing pass.
// One item at a time; a waiting result holds in the output register and stalls only
// the finish of the next item.
module fuzzy_cognitive_map_update (
    input logic  clk,
    input logic  rst_n,
    fcm_in_if.sink    in_item,
    fcm_out_if.source out_result
);
    import fcm_pkg::*;

    fcm_cmd_t cmd;
    fcm_sts_t sts;

    fcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (out_result.valid),
        .out_ready (out_result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (in_item.action),
        .concept_index (in_item.concept_index),
        .target_index  (in_item.target_index),
        .data_value    (in_item.data_value),
        .limit_value   (in_item.limit_value),
        .read_data     (out_result.read_data),
        .status        (out_result.status)
    );

endmodule
